[rtl/rnt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rnt_pkg
// shared types and codes for the ranked neighbour top-k list
// ----------------------------------------------------------------------------
package rnt_pkg;

  localparam int MAX_ENTRIES_DEF = 8;

  localparam int ADDR_W   = 16;
  localparam int DEG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] role_t;
  localparam role_t ROLE_HEAD   = 2'd0;
  localparam role_t ROLE_MEMBER = 2'd1;
  localparam role_t ROLE_OTHER  = 2'd2;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_ELECTION   = 2'd0;
  localparam phase_t PH_CONSENSUS  = 2'd1;
  localparam phase_t PH_CONNECTION = 2'd2;
  localparam phase_t PH_OTHER      = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OWN_ADDRESS = 2'd0;
  localparam cfg_idx_t CFG_OWN_DEGREE  = 2'd1;
  localparam cfg_idx_t CFG_NODE_ROLE   = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DEG_W-1:0]  degree;
    logic [ADDR_W-1:0] reference;
  } entry_t;

  // role code three saturates to other
  function automatic role_t role_sat(input logic [1:0] code);
    role_t r;
    r = (code > ROLE_OTHER) ? ROLE_OTHER : code;
    return r;
  endfunction

endpackage : rnt_pkg
`default_nettype wire

[rtl/rnt_entry_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rnt_entry_ram
// entry store for both lists, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rnt_entry_ram #(
  parameter int AW = 4
) (
  input  wire logic            clk,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output rnt_pkg::entry_t      rdata,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  rnt_pkg::entry_t      wdata
);
  import rnt_pkg::*;

  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : rnt_entry_ram
`default_nettype wire

[rtl/ranked_neighbour_topk_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ranked_neighbour_topk_list
// two bounded lists of neighbours ranked by degree then address
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// for exactly one cycle with done high and cannot be held off by the
// receiver. The selected list is walked one entry per cycle through the
// entry memory's single read port, then entries below the insertion point
// are moved down one per cycle, then the new entry is written. An invalid
// phase is answered straight from idle and an empty list goes straight to
// the write; a duplicate or a drop ends the walk with the result. Ranks
// walked plus entries moved never exceed MAX_ENTRIES. busy falls with the
// result strobe. Configuration writes are taken while busy and start are
// low.
module ranked_neighbour_topk_list #(
  parameter int MAX_ENTRIES = rnt_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [1:0]                  phase,
  input  wire logic [rnt_pkg::ADDR_W-1:0]  neighbour_address,
  input  wire logic [rnt_pkg::DEG_W-1:0]   neighbour_degree,
  input  wire logic [rnt_pkg::ADDR_W-1:0]  reference_address,
  input  wire logic [rnt_pkg::DEG_W-1:0]   announced_degree,
  output      logic                        done,
  output      logic                        accepted,
  output      logic                        inserted,
  output      logic                        evicted,
  output      logic [2:0]                  slot,
  output      logic [rnt_pkg::DEG_W-1:0]   stored_degree,
  output      logic [rnt_pkg::ADDR_W-1:0]  stored_reference,
  output      logic [3:0]                  list_size,
  output      logic [1:0]                  role_now,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [rnt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rnt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rnt_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AW = IW + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] own_address;
  logic [DEG_W-1:0]  own_degree;
  role_t             current_role;
  logic [CW-1:0]     count [2];

  logic              sel;
  logic [ADDR_W-1:0] addr_q;
  logic [DEG_W-1:0]  deg_q;
  logic [DEG_W-1:0]  sdeg_q;
  logic [ADDR_W-1:0] sref_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     pos_q;
  logic              ev_q;

  logic              re;
  logic [AW-1:0]     raddr;
  entry_t            rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  logic              accept;
  logic              sel_in;
  logic [CW-1:0]     cnt_in;
  role_t             role_eff;
  logic              hit;
  logic              above;
  logic [CW-1:0]     idx_inc;
  logic              last;
  logic              finish;
  logic [CW-1:0]     fpos;
  logic              full;
  logic              do_ins;
  logic              do_ev;
  logic [CW-1:0]     ncnt;
  logic              need_shift;
  logic [CW-1:0]     cnt_done;

  rnt_entry_ram #(
    .AW(AW)
  ) u_ram (
    .clk  (clk),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata)
  );

  assign busy      = (state != S_IDLE);
  // no register write at the edge that takes a request
  assign cfg_ready = ~busy & ~start;
  assign accept    = start & ~busy;
  assign sel_in    = (phase == PH_CONNECTION);
  assign cnt_in    = count[sel_in];
  // an empty list in election or consensus drops the node back to member
  assign role_eff  = (cnt_in == '0 && phase != PH_CONNECTION) ? ROLE_MEMBER : current_role;

  // walk comparison against the entry just read
  assign hit        = (rdata.address == addr_q);
  assign above      = (deg_q > rdata.degree) ||
                      (deg_q == rdata.degree && addr_q > rdata.address);
  assign idx_inc    = idx + CW'(1);
  assign last       = (idx_inc == cnt_q);
  assign finish     = ~hit & (above | last);
  assign fpos       = above ? idx : cnt_q;
  assign full       = (cnt_q == CW'(MAX_ENTRIES));
  assign do_ins     = ~full | above;
  assign do_ev      = full & above;
  assign ncnt       = do_ev ? CW'(MAX_ENTRIES - 1) : cnt_q;
  assign need_shift = (ncnt > fpos);
  assign cnt_done   = cnt_q + CW'(1);

  always_comb begin
    re    = 1'b0;
    raddr = {sel, IW'(idx_inc)};
    we    = 1'b0;
    waddr = {sel, IW'(idx_inc)};
    wdata = rdata;
    case (state)
      S_IDLE: begin
        re    = accept && phase != PH_OTHER && cnt_in != '0;
        raddr = {sel_in, IW'(0)};
      end
      S_WALK: begin
        if (!hit && !finish) begin
          re    = 1'b1;
          raddr = {sel, IW'(idx_inc)};
        end else if (finish && do_ins && need_shift) begin
          re    = 1'b1;
          raddr = {sel, IW'(ncnt - CW'(1))};
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = {sel, IW'(idx_inc)};
        wdata = rdata;
        if (idx != pos_q) begin
          re    = 1'b1;
          raddr = {sel, IW'(idx - CW'(1))};
        end
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = {sel, IW'(pos_q)};
        wdata = '{address: addr_q, degree: sdeg_q, reference: sref_q};
      end
      default: begin
        re = 1'b0;
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      count[0]     <= '0;
      count[1]     <= '0;
      current_role <= ROLE_MEMBER;
      own_address  <= '0;
      own_degree   <= '0;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ADDRESS: own_address  <= cfg_data;
          CFG_OWN_DEGREE:  own_degree   <= cfg_data[DEG_W-1:0];
          CFG_NODE_ROLE:   current_role <= role_sat(cfg_data[1:0]);
          default:         ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            sel    <= sel_in;
            addr_q <= neighbour_address;
            deg_q  <= neighbour_degree;
            if (role_eff == ROLE_HEAD) begin
              sdeg_q <= announced_degree - own_degree;
              sref_q <= reference_address - own_address;
            end else begin
              sdeg_q <= neighbour_degree;
              sref_q <= reference_address;
            end
            if (phase == PH_OTHER) begin
              done             <= 1'b1;
              accepted         <= 1'b0;
              inserted         <= 1'b0;
              evicted          <= 1'b0;
              slot             <= '0;
              stored_degree    <= '0;
              stored_reference <= '0;
              list_size        <= '0;
              role_now         <= current_role;
            end else if (cnt_in == '0) begin
              current_role <= role_eff;
              cnt_q        <= '0;
              pos_q        <= '0;
              ev_q         <= 1'b0;
              state        <= S_WRITE;
            end else begin
              cnt_q <= cnt_in;
              idx   <= '0;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (hit || (finish && !do_ins)) begin
            // duplicate ahead of the insertion point, or dropped after a full list
            done             <= 1'b1;
            accepted         <= 1'b1;
            inserted         <= 1'b0;
            evicted          <= 1'b0;
            slot             <= '0;
            stored_degree    <= '0;
            stored_reference <= '0;
            list_size        <= 4'(cnt_q);
            role_now         <= current_role;
            state            <= S_IDLE;
          end else if (finish) begin
            pos_q <= fpos;
            cnt_q <= ncnt;
            ev_q  <= do_ev;
            if (need_shift) begin
              idx   <= ncnt - CW'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            idx <= idx_inc;
          end
        end
        S_SHIFT: begin
          if (idx == pos_q) begin
            state <= S_WRITE;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_WRITE: begin
          count[sel]       <= cnt_done;
          done             <= 1'b1;
          accepted         <= 1'b1;
          inserted         <= 1'b1;
          evicted          <= ev_q;
          slot             <= 3'(pos_q);
          stored_degree    <= sdeg_q;
          stored_reference <= sref_q;
          list_size        <= 4'(cnt_done);
          role_now         <= current_role;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : ranked_neighbour_topk_list
`default_nettype wire

[tb/sv/tb_ranked_neighbour_topk_list.sv]
// ----------------------------------------------------------------------------
// tb_ranked_neighbour_topk_list
// self-checking bench for the ranked neighbour top-k lists
// ----------------------------------------------------------------------------
// A short table of directed requests (insertion into empty lists, duplicates
// met before and after the insertion point, ties on degree, drops and
// evictions on full lists, head-role difference storage with wrap-around,
// the invalid phase, saturation of role code three) is followed by phases
// of random requests under different register settings and sender idling.
// Typed rows are checked against their written outcomes, every other result
// against a predictor that keeps its own copy of both lists, the role and the registers.
module tb_ranked_neighbour_topk_list;
  import rnt_pkg::*;

  localparam int RANKS           = MAX_ENTRIES_DEF;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_ANNOUNCE, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] address;
    logic [7:0]  degree;
    logic [15:0] carried_ref;
    logic [7:0]  carried_deg;
  } announce_t;

  typedef struct packed {
    logic        accepted;
    logic        inserted;
    logic        evicted;
    logic [2:0]  slot;
    logic [7:0]  stored_degree;
    logic [15:0] stored_reference;
    logic [3:0]  list_size;
    role_t       role_now;
  } outcome_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        typed;
    cfg_idx_t    idx;
    logic [15:0] data;
    announce_t   ann;
    outcome_t    want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  phase_t      phase = PH_ELECTION;
  logic [15:0] neighbour_address = '0;
  logic [7:0]  neighbour_degree = '0;
  logic [15:0] reference_address = '0;
  logic [7:0]  announced_degree = '0;
  logic        done;
  logic        accepted;
  logic        inserted;
  logic        evicted;
  logic [2:0]  slot;
  logic [7:0]  stored_degree;
  logic [15:0] stored_reference;
  logic [3:0]  list_size;
  logic [1:0]  role_now;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_OWN_ADDRESS;
  logic [15:0] cfg_data = '0;

  // predictor state: index 0 head candidates, index 1 bridge candidates
  logic [15:0] cand_addr [2][RANKS];
  logic [7:0]  cand_deg  [2][RANKS];
  logic [15:0] cand_ref  [2][RANKS];
  int          cand_count [2];
  role_t       role_q;
  logic [15:0] own_addr_q;
  logic [7:0]  own_deg_q;

  outcome_t    pending_outcomes [$];
  plan_row_t   plan [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  ranked_neighbour_topk_list dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .phase             (phase),
    .neighbour_address (neighbour_address),
    .neighbour_degree  (neighbour_degree),
    .reference_address (reference_address),
    .announced_degree  (announced_degree),
    .done              (done),
    .accepted          (accepted),
    .inserted          (inserted),
    .evicted           (evicted),
    .slot              (slot),
    .stored_degree     (stored_degree),
    .stored_reference  (stored_reference),
    .list_size         (list_size),
    .role_now          (role_now),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t outcome_of(input int acc, input int ins, input int ev,
                                          input int pos, input logic [7:0] sdeg,
                                          input logic [15:0] sref, input int len,
                                          input role_t role);
    outcome_t o;
    o = {1'(acc), 1'(ins), 1'(ev), 3'(pos), sdeg, sref, 4'(len), role};
    return o;
  endfunction

  function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [15:0] d);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG_WRITE;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic plan_row_t ann_row(input phase_t ph, input logic [15:0] addr,
                                        input logic [7:0] deg, input logic [15:0] refa,
                                        input logic [7:0] adeg);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ANNOUNCE;
    r.ann = {ph, addr, deg, refa, adeg};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input phase_t ph, input logic [15:0] addr,
                                          input logic [7:0] deg, input logic [15:0] refa,
                                          input logic [7:0] adeg, input outcome_t want);
    plan_row_t r;
    r = ann_row(ph, addr, deg, refa, adeg);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic void note_reg(input cfg_idx_t idx, input logic [15:0] d);
    case (idx)
      CFG_OWN_ADDRESS: own_addr_q = d;
      CFG_OWN_DEGREE:  own_deg_q = d[7:0];
      CFG_NODE_ROLE:   role_q = (d[1:0] > ROLE_OTHER) ? ROLE_OTHER : role_t'(d[1:0]);
      default: ;
    endcase
  endfunction

  // walk the selected list, then insert, evict or drop
  function automatic outcome_t rank_announce(input announce_t a);
    outcome_t    o;
    int          sel;
    int          cnt;
    int          pos;
    int          i;
    bit          broke;
    bit          dup;
    bit          ins;
    bit          ev;
    logic [7:0]  sdeg;
    logic [15:0] sref;
    o = '0;
    pos = 0;
    broke = 0;
    dup = 0;
    ins = 0;
    ev = 0;
    sdeg = '0;
    sref = '0;
    if (a.phase == PH_OTHER) begin
      o.role_now = role_q;
      return o;
    end
    o.accepted = 1'b1;
    sel = (a.phase == PH_CONNECTION) ? 1 : 0;
    cnt = cand_count[sel];
    if (cnt == 0) begin
      if (a.phase != PH_CONNECTION) role_q = ROLE_MEMBER;
      ins = 1;
    end else begin
      i = 0;
      while (i < cnt && !broke && !dup) begin
        if (cand_addr[sel][i] == a.address) begin
          dup = 1;
        end else if (a.degree > cand_deg[sel][i] ||
                     (a.degree == cand_deg[sel][i] && a.address > cand_addr[sel][i])) begin
          broke = 1;
        end else begin
          pos++;
        end
        i++;
      end
      if (dup) begin
        o.list_size = 4'(cnt);
        o.role_now = role_q;
        return o;
      end
      if (cnt < RANKS) begin
        ins = 1;
      end else if (broke) begin
        ins = 1;
        ev = 1;
        cnt = RANKS - 1;
      end
    end
    if (ins) begin
      if (role_q == ROLE_HEAD) begin
        sref = a.carried_ref - own_addr_q;
        sdeg = a.carried_deg - own_deg_q;
      end else begin
        sref = a.carried_ref;
        sdeg = a.degree;
      end
      for (i = cnt; i > pos; i--) begin
        cand_addr[sel][i] = cand_addr[sel][i-1];
        cand_deg[sel][i]  = cand_deg[sel][i-1];
        cand_ref[sel][i]  = cand_ref[sel][i-1];
      end
      cand_addr[sel][pos] = a.address;
      cand_deg[sel][pos]  = sdeg;
      cand_ref[sel][pos]  = sref;
      cnt++;
    end
    cand_count[sel] = cnt;
    o.inserted = ins;
    o.evicted = ev;
    o.slot = ins ? 3'(pos) : 3'd0;
    o.stored_degree = sdeg;
    o.stored_reference = sref;
    o.list_size = 4'(cnt);
    o.role_now = role_q;
    return o;
  endfunction

  // most requests aim at stored addresses, small addresses and the tail degree
  function automatic announce_t draw_announce();
    announce_t a;
    int        sel;
    int        cnt;
    int        r;
    a.phase = ($urandom_range(99) < 10) ? PH_OTHER : phase_t'($urandom_range(2));
    sel = (a.phase == PH_CONNECTION) ? 1 : 0;
    cnt = cand_count[sel];
    r = $urandom_range(99);
    if (r < 35 && cnt > 0) a.address = cand_addr[sel][$urandom_range(cnt - 1)];
    else if (r < 60) a.address = 16'($urandom_range(15));
    else a.address = 16'($urandom);
    r = $urandom_range(99);
    if (r < 12) a.degree = 8'h00;
    else if (r < 24) a.degree = 8'hFF;
    else if (r < 55 && cnt > 0) a.degree = cand_deg[sel][cnt-1] + 8'($urandom_range(4)) - 8'd2;
    else a.degree = 8'($urandom);
    r = $urandom_range(99);
    if (r < 5) a.carried_ref = 16'h0000;
    else if (r < 10) a.carried_ref = 16'hFFFF;
    else a.carried_ref = 16'($urandom);
    a.carried_deg = 8'($urandom);
    return a;
  endfunction

  task automatic report_mismatch(input string what, input outcome_t want, input outcome_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s: exp acc=%0d ins=%0d ev=%0d slot=%0d deg=%h ref=%h len=%0d role=%0d",
               what, want.accepted, want.inserted, want.evicted, want.slot,
               want.stored_degree, want.stored_reference, want.list_size, want.role_now,
               "\n  got acc=%0d ins=%0d ev=%0d slot=%0d deg=%h ref=%h len=%0d role=%0d",
               got.accepted, got.inserted, got.evicted, got.slot,
               got.stored_degree, got.stored_reference, got.list_size, got.role_now);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    note_reg(idx, d);
  endtask

  task automatic send_announce(input announce_t a, input logic typed, input outcome_t want);
    outcome_t predicted;
    start             <= 1'b1;
    phase             <= a.phase;
    neighbour_address <= a.address;
    neighbour_degree  <= a.degree;
    reference_address <= a.carried_ref;
    announced_degree  <= a.carried_deg;
    do @(posedge clk); while (busy);
    predicted = rank_announce(a);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // caller has lowered start in this step; always waits on the clock before it returns
  task automatic wait_drained();
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && done) begin
      got = {accepted, inserted, evicted, slot, stored_degree, stored_reference,
             list_size, role_t'(role_now)};
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else if (got !== pending_outcomes[0]) begin
        report_mismatch("result mismatch", pending_outcomes[0], got);
        void'(pending_outcomes.pop_front());
      end else begin
        void'(pending_outcomes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int        k;
    int        p;
    int        n;
    int        pause_at;
    int        idle_pct;
    logic [15:0] addr_d;
    logic [7:0]  deg_d;
    announce_t a;

    cand_count[0] = 0;
    cand_count[1] = 0;
    role_q = ROLE_MEMBER;
    own_addr_q = '0;
    own_deg_q = '0;

    plan.push_back(reg_row(CFG_OWN_ADDRESS, 16'h0100));
    plan.push_back(reg_row(CFG_OWN_DEGREE, 16'h0010));
    plan.push_back(reg_row(CFG_NODE_ROLE, {14'd0, ROLE_HEAD}));
    plan.push_back(typed_row(PH_OTHER, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF,
                             outcome_of(0, 0, 0, 0, 8'h00, 16'h0000, 0, ROLE_HEAD)));
    // empty bridge list keeps the head role and stores differences
    plan.push_back(typed_row(PH_CONNECTION, 16'hFFFF, 8'hFF, 16'h0050, 8'h05,
                             outcome_of(1, 1, 0, 0, 8'hF5, 16'hFF50, 1, ROLE_HEAD)));
    // empty head list in election switches to member first
    plan.push_back(typed_row(PH_ELECTION, 16'h1234, 8'h80, 16'hABCD, 8'h11,
                             outcome_of(1, 1, 0, 0, 8'h80, 16'hABCD, 1, ROLE_MEMBER)));
    plan.push_back(typed_row(PH_ELECTION, 16'h1234, 8'h01, 16'h0000, 8'h00,
                             outcome_of(1, 0, 0, 0, 8'h00, 16'h0000, 1, ROLE_MEMBER)));
    plan.push_back(ann_row(PH_CONSENSUS, 16'h0001, 8'h40, 16'h0002, 8'h00));
    // duplicate address sitting after the insertion point
    plan.push_back(ann_row(PH_ELECTION, 16'h0001, 8'hFF, 16'h0003, 8'h00));
    plan.push_back(ann_row(PH_CONSENSUS, 16'h2000, 8'h80, 16'h0004, 8'h00));
    plan.push_back(ann_row(PH_ELECTION, 16'h0010, 8'h00, 16'h0005, 8'h00));
    plan.push_back(ann_row(PH_ELECTION, 16'h0100, 8'h20, 16'h0006, 8'h00));
    plan.push_back(ann_row(PH_CONSENSUS, 16'h0101, 8'h20, 16'h0007, 8'h00));
    plan.push_back(ann_row(PH_ELECTION, 16'h0102, 8'h20, 16'h0008, 8'h00));
    // full list: lands after the tail, then ranks first
    plan.push_back(typed_row(PH_ELECTION, 16'h0003, 8'h00, 16'h1111, 8'h22,
                             outcome_of(1, 0, 0, 0, 8'h00, 16'h0000, 8, ROLE_MEMBER)));
    plan.push_back(typed_row(PH_ELECTION, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF,
                             outcome_of(1, 1, 1, 0, 8'hFF, 16'hFFFF, 8, ROLE_MEMBER)));
    // role code three saturates to other
    plan.push_back(reg_row(CFG_NODE_ROLE, 16'hFFFF));
    plan.push_back(typed_row(PH_OTHER, 16'h0000, 8'h00, 16'h0000, 8'h00,
                             outcome_of(0, 0, 0, 0, 8'h00, 16'h0000, 0, ROLE_OTHER)));
    plan.push_back(reg_row(CFG_UNUSED, 16'hFFFF));
    plan.push_back(reg_row(CFG_OWN_ADDRESS, 16'hFFFF));
    plan.push_back(reg_row(CFG_OWN_DEGREE, 16'hFFFF));
    plan.push_back(reg_row(CFG_NODE_ROLE, {14'd0, ROLE_HEAD}));
    plan.push_back(typed_row(PH_CONNECTION, 16'h4000, 8'h10, 16'h0000, 8'h00,
                             outcome_of(1, 1, 0, 1, 8'h01, 16'h0001, 2, ROLE_HEAD)));
    plan.push_back(ann_row(PH_ELECTION, 16'h7777, 8'hFF, 16'h1234, 8'h99));
    plan.push_back(ann_row(PH_CONNECTION, 16'h4000, 8'hFF, 16'h8000, 8'h00));
    plan.push_back(ann_row(PH_CONNECTION, 16'h4000, 8'h00, 16'h0000, 8'h00));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == ROW_REG_WRITE) begin
        start <= 1'b0;
        wait_drained();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        cfg_valid <= 1'b0;
        send_announce(plan[k].ann, plan[k].typed, plan[k].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      start <= 1'b0;
      wait_drained();
      addr_d = (p == 1) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom);
      deg_d  = (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : 8'($urandom);
      write_reg(CFG_OWN_ADDRESS, addr_d);
      write_reg(CFG_OWN_DEGREE, {8'($urandom), deg_d});
      write_reg(CFG_NODE_ROLE, {14'($urandom), 2'(p % 4)});
      cfg_valid <= 1'b0;
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 79 : 20;
      pause_at = $urandom_range(ITEMS_PER_PHASE - 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == pause_at) begin
          start <= 1'b0;
          wait_drained();
        end
        idle_gap(idle_pct);
        a = draw_announce();
        send_announce(a, 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (2 * RANKS + 4) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
